// File: rtl/srrt_pkg.sv
// shared constants and types for the selective repeat receive tracker
package srrt_pkg;

    localparam int SEQ_W            = 16;
    localparam int PTR_W            = SEQ_W + 1;
    localparam int SEQ_SPACE        = 65536;
    localparam int HEADER_BYTES     = 16;
    localparam int MAX_PACKET_BYTES = 500;

    localparam int MODE_W   = 16;
    localparam int STAMP_W  = 64;
    localparam int BYTES_W  = 9;
    localparam int STRIDE_W = 11;
    localparam int OFF_W    = 26;
    localparam int PROD_W   = SEQ_W + STRIDE_W;
    localparam int ACT_W    = 3;
    localparam int RCODE_W  = 2;

    localparam int ROW_W      = 32;
    localparam int ROW_BIT_W  = 5;
    localparam int ROWS       = SEQ_SPACE / ROW_W;
    localparam int ROW_ADDR_W = SEQ_W - ROW_BIT_W;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_USER_W = ACT_W + RCODE_W;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(484);

    localparam logic [MODE_W-1:0] CODE_DATA    = MODE_W'(0);
    localparam logic [MODE_W-1:0] CODE_ACK     = MODE_W'(1);
    localparam logic [MODE_W-1:0] CODE_FIN     = MODE_W'(2);
    localparam logic [MODE_W-1:0] CODE_FIN_ACK = MODE_W'(3);

    localparam logic [RCODE_W-1:0] RCODE_NONE    = RCODE_W'(0);
    localparam logic [RCODE_W-1:0] RCODE_ACK     = RCODE_W'(1);
    localparam logic [RCODE_W-1:0] RCODE_FIN_ACK = RCODE_W'(3);

    localparam logic [ACT_W-1:0] ACT_IGNORED = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_NEW     = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_DUP     = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_FIN_ACK = ACT_W'(3);
    localparam logic [ACT_W-1:0] ACT_CLOSED  = ACT_W'(4);

    typedef struct packed {
        logic                  en;
        logic [ROW_ADDR_W-1:0] addr;
        logic [ROW_W-1:0]      data;
    } t_map_wr;

endpackage

// File: rtl/srrt_seen_mem.sv
// received map memory, one row per cycle, with a clearing sweep after reset
module srrt_seen_mem
    import srrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ROW_ADDR_W-1:0] i_rd_addr,
    input  t_map_wr               i_wr,
    output logic [ROW_W-1:0]      o_rd_data,
    output logic                  o_clearing
);

    logic [ROW_W-1:0]      r_mem [ROWS];
    logic [ROW_W-1:0]      r_rd_data;
    logic [ROW_ADDR_W-1:0] r_clr_addr;
    logic                  r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ROW_ADDR_W'(1);
            if (r_clr_addr == {ROW_ADDR_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// File: rtl/selective_repeat_receive_tracker.sv
// selective repeat receive tracker: header sequencer, offset multiply and in-order scan
// ignored, fin and closing headers pass decode and done; duplicates and out-of-order
// data pass decode, check and done; data filling the next-expected slot adds scan read
// and scan check, one map bit per scan cycle, plus a scan read per row crossed. done
// waits while the output is stalled; the next header is taken the cycle after the result
// registers. after reset the map is cleared one row per cycle (2048 rows), tready low.
module selective_repeat_receive_tracker
    import srrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [STRIDE_W-1:0]   i_cfg_wr_data,    // payload_stride
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // seq_num, sent_stamp, pkt_bytes
    input  logic [MODE_W-1:0]     i_s_axis_tuser,   // mode
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // reply_seq, reply_stamp, write_enable, write_offset, write_length,
    // next_expected, highest_acked
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [OUT_USER_W-1:0] o_m_axis_tuser    // action, reply_code
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_RECV,
        PH_CLOSING,
        PH_CLOSED
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [STRIDE_W-1:0]   r_stride;
    logic [MODE_W-1:0]     r_mode;
    logic [SEQ_W-1:0]      r_seq;
    logic [STAMP_W-1:0]    r_stamp;
    logic [BYTES_W-1:0]    r_bytes;
    logic [PTR_W-1:0]      r_next;
    logic signed [PTR_W-1:0] r_top;
    logic [SEQ_W-1:0]      r_fin_seq;
    logic [STAMP_W-1:0]    r_fin_stamp;

    logic [ACT_W-1:0]      r_act;
    logic [RCODE_W-1:0]    r_code;
    logic [SEQ_W-1:0]      r_rseq;
    logic [STAMP_W-1:0]    r_rstamp;
    logic                  r_we;
    logic [OFF_W-1:0]      r_off;
    logic [BYTES_W-1:0]    r_len;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [BYTES_W-1:0]    w_bytes;
    logic [PROD_W-1:0]     w_prod;
    logic [ROW_ADDR_W-1:0] w_rd_addr;
    logic [ROW_W-1:0]      w_rd_data;
    logic                  w_clearing;
    t_map_wr               w_wr;
    logic                  w_seq_bit;
    logic                  w_scan_bit;
    logic signed [PTR_W-1:0] w_seq_s;

    assign w_bytes   = (r_bytes > BYTES_W'(MAX_PACKET_BYTES)) ?
                       BYTES_W'(MAX_PACKET_BYTES) : r_bytes;
    assign w_prod    = PROD_W'(r_seq) * PROD_W'(r_stride);
    assign w_seq_s   = $signed({1'b0, r_seq});
    assign w_seq_bit = w_rd_data[r_seq[ROW_BIT_W-1:0]];
    assign w_scan_bit = w_rd_data[r_next[ROW_BIT_W-1:0]];
    assign w_rd_addr = (r_state == S_SCAN_RD || r_state == S_SCAN_CHK) ?
                       r_next[SEQ_W-1:ROW_BIT_W] : r_seq[SEQ_W-1:ROW_BIT_W];

    always_comb begin
        w_wr.en   = (r_state == S_CHECK) && !w_seq_bit;
        w_wr.addr = r_seq[SEQ_W-1:ROW_BIT_W];
        w_wr.data = w_rd_data | (ROW_W'(1) << r_seq[ROW_BIT_W-1:0]);
    end

    srrt_seen_mem u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .i_wr       (w_wr),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    assign o_s_axis_tready = (r_state == S_IDLE) && !w_clearing;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_wr_en) begin
            r_stride <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_RECV;
            r_next      <= '0;
            r_top       <= '1;
            r_fin_seq   <= '0;
            r_fin_stamp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid && o_s_axis_tready) begin
                        r_mode  <= i_s_axis_tuser;
                        r_seq   <= i_s_axis_tdata[15:0];
                        r_stamp <= i_s_axis_tdata[79:16];
                        r_bytes <= i_s_axis_tdata[88:80];
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_we  <= 1'b0;
                    r_off <= '0;
                    r_len <= '0;
                    priority if (r_phase == PH_CLOSING) begin
                        r_state <= S_DONE;
                        if (w_bytes == BYTES_W'(HEADER_BYTES) && r_mode == CODE_ACK) begin
                            r_phase  <= PH_CLOSED;
                            r_act    <= ACT_CLOSED;
                            r_code   <= RCODE_NONE;
                            r_rseq   <= '0;
                            r_rstamp <= '0;
                        end else begin
                            r_act    <= ACT_FIN_ACK;
                            r_code   <= RCODE_FIN_ACK;
                            r_rseq   <= r_fin_seq;
                            r_rstamp <= r_fin_stamp;
                        end
                    end else if (r_phase != PH_RECV
                                 || w_bytes < BYTES_W'(HEADER_BYTES)) begin
                        r_act    <= ACT_IGNORED;
                        r_code   <= RCODE_NONE;
                        r_rseq   <= '0;
                        r_rstamp <= '0;
                        r_state  <= S_DONE;
                    end else if (r_mode == CODE_FIN) begin
                        r_phase     <= PH_CLOSING;
                        r_fin_seq   <= r_seq;
                        r_fin_stamp <= r_stamp;
                        r_act       <= ACT_FIN_ACK;
                        r_code      <= RCODE_FIN_ACK;
                        r_rseq      <= r_seq;
                        r_rstamp    <= r_stamp;
                        r_state     <= S_DONE;
                    end else if (r_mode == CODE_DATA) begin
                        if (w_seq_s > r_top) begin
                            r_top <= w_seq_s;
                        end
                        r_code   <= RCODE_ACK;
                        r_rseq   <= r_seq;
                        r_rstamp <= r_stamp;
                        r_state  <= S_CHECK;
                    end else begin
                        r_act    <= ACT_IGNORED;
                        r_code   <= RCODE_NONE;
                        r_rseq   <= '0;
                        r_rstamp <= '0;
                        r_state  <= S_DONE;
                    end
                end
                S_CHECK: begin
                    if (w_seq_bit) begin
                        r_act   <= ACT_DUP;
                        r_off   <= '0;
                        r_len   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_act <= ACT_NEW;
                        r_we  <= 1'b1;
                        r_off <= w_prod[OFF_W-1:0];
                        r_len <= w_bytes - BYTES_W'(HEADER_BYTES);
                        if (!r_next[SEQ_W] && r_next[SEQ_W-1:0] == r_seq) begin
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (!r_next[SEQ_W] && w_scan_bit) begin
                        r_next <= r_next + PTR_W'(1);
                        if (r_next[ROW_BIT_W-1:0] == {ROW_BIT_W{1'b1}}) begin
                            r_state <= S_SCAN_RD;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= {r_code, r_act};
                        r_out_data  <= {2'b00, r_top, r_next, r_len, r_off, r_we,
                                        r_rstamp, r_rseq};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_s_axis_tready)
        else $error("item accepted during map clear");

    a_write_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[80]) |-> (o_m_axis_tuser[2:0] == ACT_NEW))
        else $error("payload write on a non-new result");

    a_next_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_next >= $past(r_next)))
        else $error("next expected pointer went backward");

    a_next_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next[SEQ_W] |-> (r_next[SEQ_W-1:0] == '0))
        else $error("next expected pointer beyond sequence space");
`endif

endmodule
